FILE: hdl/svspp_pkg.sv
// Types and constants for the servo status packet parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package svspp_pkg;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_TICK  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_SYNC     = 4'd1,
        ST_BADLEN   = 4'd2,
        ST_TOOLONG  = 4'd3,
        ST_CHECKSUM = 4'd4,
        ST_SHORT    = 4'd5,
        ST_IDMIS    = 4'd6,
        ST_SERVO    = 4'd7,
        ST_RANGE    = 4'd8,
        ST_TIMEOUT  = 4'd9
    } status_t;

    localparam logic [7:0]  HEADER_BYTE      = 8'hFF;
    localparam logic [7:0]  LEN_MIN          = 8'd2;
    localparam logic [7:0]  LEN_MAX          = 8'd250;
    localparam logic [7:0]  FRAME_OVERHEAD   = 8'd4;
    localparam logic [7:0]  MIN_PACKET_BYTES = 8'd8;
    localparam logic [11:0] POSITION_MAX     = 12'd4095;
    localparam logic [15:0] TIMEOUT_RESET    = 16'd5000;

    // Byte positions inside the packet: header, header, id, length, error, params.
    localparam int IDX_ERROR = 4;
    localparam int IDX_POS_L = 5;
    localparam int IDX_POS_H = 6;

endpackage

`default_nettype wire

FILE: hdl/svspp_if.sv
// Valid/ready channel interfaces for the servo status packet parser.
// Depends on svspp_pkg for the kind and status types.
`default_nettype none

interface svspp_cmd_if
    import svspp_pkg::*;
;
    logic        valid;
    logic        ready;
    kind_t       kind;
    logic [7:0]  expected_id;
    logic [7:0]  rx_byte;

    modport source (output valid, kind, expected_id, rx_byte, input ready);
    modport sink   (input valid, kind, expected_id, rx_byte, output ready);
endinterface

interface svspp_report_if
    import svspp_pkg::*;
;
    logic        valid;
    logic        ready;
    status_t     status;
    logic [11:0] position;
    logic [7:0]  servo_error;
    logic [4:0]  packet_length;

    modport source (output valid, status, position, servo_error, packet_length, input ready);
    modport sink   (input valid, status, position, servo_error, packet_length, output ready);
endinterface

`default_nettype wire

FILE: hdl/servo_status_packet_parser_top.sv
// Servo status packet parser: top level with the whole parsing datapath.
// Depends on svspp_pkg and the channel interfaces in svspp_if.sv.
// Usage:
//   cmd carries one item per handshake: a start item (kind start) arms the
//   parser with the expected servo id, byte items feed the received serial
//   stream, and tick items measure idle time toward the timeout.
//   report carries one item when a reply ends or parsing is abandoned: status,
//   position, servo error byte, packet length. Most items give no report.
//   cfg_we/cfg_wdata write the timeout in ticks; write only while idle.
// Latency and throughput:
//   A command item is parsed in the cycle it is accepted; its report item is
//   valid on the next cycle from the output register. One item per cycle is
//   accepted, limited only by the output register: cmd.ready is high when
//   that register is empty or is being drained in the same cycle.
// Reset:
//   The parser comes out of reset idle with timeout 5000 ticks; bytes and
//   ticks are ignored until a start item arrives.
// Stall:
//   When report.ready is low with a report pending, cmd.ready drops and the
//   pending report is held until taken.
`default_nettype none

module servo_status_packet_parser_top
    import svspp_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 16,
    parameter int SYNC_LIMIT       = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    svspp_cmd_if.sink        cmd,
    svspp_report_if.source   report,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);

    localparam int IW   = $clog2(MAX_PACKET_BYTES);
    localparam int SF_W = $clog2(SYNC_LIMIT + 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HUNT0,
        PH_HUNT1,
        PH_ID,
        PH_LEN,
        PH_BODY
    } phase_t;

    phase_t            phase_reg,         phase_next;
    logic [SF_W-1:0]   sync_failures_reg, sync_failures_next;
    logic [7:0]        armed_id_reg,      armed_id_next;
    logic [IW-1:0]     byte_index_reg,    byte_index_next;
    logic [7:0]        length_field_reg,  length_field_next;
    logic [7:0]        running_sum_reg,   running_sum_next;
    logic [7:0]        reply_id_reg,      reply_id_next;
    logic [7:0]        reply_error_reg,   reply_error_next;
    logic [7:0]        position_low_reg,  position_low_next;
    logic [7:0]        position_high_reg, position_high_next;
    logic [15:0]       idle_count_reg,    idle_count_next;
    logic [15:0]       timeout_ticks_reg;

    logic              out_valid_reg,     out_valid_next;
    status_t           out_status_reg,    out_status_next;
    logic [11:0]       out_position_reg,  out_position_next;
    logic [7:0]        out_error_reg,     out_error_next;
    logic [4:0]        out_length_reg,    out_length_next;

    logic              accept;
    logic              emit;
    status_t           res_status;
    logic [11:0]       res_position;
    logic [7:0]        res_error;
    logic [4:0]        res_length;
    logic [SF_W:0]     sync_inc;
    logic [8:0]        len_plus_hdr;
    logic [7:0]        total;
    logic [7:0]        index_ext;
    logic [15:0]       tick_count;
    logic [15:0]       position_word;

    assign cmd.ready = !out_valid_reg || report.ready;
    assign accept    = cmd.valid && cmd.ready;

    assign sync_inc      = {1'b0, sync_failures_reg} + (SF_W + 1)'(1);
    assign len_plus_hdr  = {1'b0, cmd.rx_byte} + {1'b0, FRAME_OVERHEAD};
    assign total         = length_field_reg + FRAME_OVERHEAD;
    assign index_ext     = 8'(byte_index_reg);
    assign tick_count    = (idle_count_reg == 16'hFFFF) ? idle_count_reg
                                                        : idle_count_reg + 16'd1;
    assign position_word = {position_high_reg, position_low_reg};

    always_comb
    begin
        phase_next         = phase_reg;
        sync_failures_next = sync_failures_reg;
        armed_id_next      = armed_id_reg;
        byte_index_next    = byte_index_reg;
        length_field_next  = length_field_reg;
        running_sum_next   = running_sum_reg;
        reply_id_next      = reply_id_reg;
        reply_error_next   = reply_error_reg;
        position_low_next  = position_low_reg;
        position_high_next = position_high_reg;
        idle_count_next    = idle_count_reg;
        emit               = 1'b0;
        res_status         = ST_OK;
        res_position       = '0;
        res_error          = '0;
        res_length         = '0;

        if (accept)
        begin
            unique case (cmd.kind)
                KIND_START:
                begin
                    armed_id_next      = cmd.expected_id;
                    sync_failures_next = '0;
                    byte_index_next    = '0;
                    length_field_next  = '0;
                    running_sum_next   = '0;
                    reply_id_next      = '0;
                    reply_error_next   = '0;
                    position_low_next  = '0;
                    position_high_next = '0;
                    idle_count_next    = '0;
                    phase_next         = PH_HUNT0;
                end
                KIND_BYTE:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        idle_count_next = '0;
                    end
                    unique case (phase_reg) inside
                        PH_HUNT0, PH_HUNT1:
                        begin
                            if (cmd.rx_byte != HEADER_BYTE)
                            begin
                                // Any non-0xFF byte while hunting counts as a sync failure.
                                sync_failures_next = sync_inc[SF_W-1:0];
                                if (sync_inc >= (SF_W + 1)'(SYNC_LIMIT))
                                begin
                                    emit       = 1'b1;
                                    res_status = ST_SYNC;
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    phase_next = PH_HUNT0;
                                end
                            end
                            else
                            begin
                                phase_next = (phase_reg == PH_HUNT0) ? PH_HUNT1 : PH_ID;
                            end
                        end
                        PH_ID:
                        begin
                            reply_id_next    = cmd.rx_byte;
                            running_sum_next = cmd.rx_byte;
                            phase_next       = PH_LEN;
                        end
                        PH_LEN:
                        begin
                            length_field_next = cmd.rx_byte;
                            running_sum_next  = running_sum_reg + cmd.rx_byte;
                            if (cmd.rx_byte < LEN_MIN || cmd.rx_byte > LEN_MAX)
                            begin
                                emit       = 1'b1;
                                res_status = ST_BADLEN;
                                phase_next = PH_IDLE;
                            end
                            else if (len_plus_hdr > 9'(MAX_PACKET_BYTES))
                            begin
                                emit       = 1'b1;
                                res_status = ST_TOOLONG;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                byte_index_next = IW'(IDX_ERROR);
                                phase_next      = PH_BODY;
                            end
                        end
                        PH_BODY:
                        begin
                            if (index_ext + 8'd1 < total)
                            begin
                                if (byte_index_reg == IW'(IDX_ERROR))
                                begin
                                    reply_error_next = cmd.rx_byte;
                                end
                                else if (byte_index_reg == IW'(IDX_POS_L))
                                begin
                                    position_low_next = cmd.rx_byte;
                                end
                                else if (byte_index_reg == IW'(IDX_POS_H))
                                begin
                                    position_high_next = cmd.rx_byte;
                                end
                                running_sum_next = running_sum_reg + cmd.rx_byte;
                                byte_index_next  = byte_index_reg + IW'(1);
                            end
                            else
                            begin
                                // Checksum byte: the checks below run in priority order.
                                emit       = 1'b1;
                                phase_next = PH_IDLE;
                                if (~running_sum_reg != cmd.rx_byte)
                                begin
                                    res_status = ST_CHECKSUM;
                                end
                                else
                                begin
                                    res_error  = reply_error_reg;
                                    res_length = total[4:0];
                                    if (total < MIN_PACKET_BYTES)
                                    begin
                                        res_status = ST_SHORT;
                                    end
                                    else if (reply_id_reg != armed_id_reg)
                                    begin
                                        res_status = ST_IDMIS;
                                    end
                                    else if (reply_error_reg != 8'd0)
                                    begin
                                        res_status = ST_SERVO;
                                    end
                                    else if (position_word > 16'(POSITION_MAX))
                                    begin
                                        res_status = ST_RANGE;
                                    end
                                    else
                                    begin
                                        res_status   = ST_OK;
                                        res_position = position_word[11:0];
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                KIND_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        idle_count_next = tick_count;
                        if (tick_count >= timeout_ticks_reg)
                        begin
                            emit       = 1'b1;
                            res_status = ST_TIMEOUT;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        out_status_next   = out_status_reg;
        out_position_next = out_position_reg;
        out_error_next    = out_error_reg;
        out_length_next   = out_length_reg;
        if (emit)
        begin
            out_valid_next    = 1'b1;
            out_status_next   = res_status;
            out_position_next = res_position;
            out_error_next    = res_error;
            out_length_next   = res_length;
        end
        else if (report.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            sync_failures_reg <= '0;
            armed_id_reg      <= '0;
            byte_index_reg    <= '0;
            length_field_reg  <= '0;
            running_sum_reg   <= '0;
            reply_id_reg      <= '0;
            reply_error_reg   <= '0;
            position_low_reg  <= '0;
            position_high_reg <= '0;
            idle_count_reg    <= '0;
            timeout_ticks_reg <= TIMEOUT_RESET;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            sync_failures_reg <= sync_failures_next;
            armed_id_reg      <= armed_id_next;
            byte_index_reg    <= byte_index_next;
            length_field_reg  <= length_field_next;
            running_sum_reg   <= running_sum_next;
            reply_id_reg      <= reply_id_next;
            reply_error_reg   <= reply_error_next;
            position_low_reg  <= position_low_next;
            position_high_reg <= position_high_next;
            idle_count_reg    <= idle_count_next;
            out_valid_reg     <= out_valid_next;
            if (cfg_we)
            begin
                timeout_ticks_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg   <= out_status_next;
        out_position_reg <= out_position_next;
        out_error_reg    <= out_error_next;
        out_length_reg   <= out_length_next;
    end

    assign report.valid         = out_valid_reg;
    assign report.status        = out_status_reg;
    assign report.position      = out_position_reg;
    assign report.servo_error   = out_error_reg;
    assign report.packet_length = out_length_reg;

    // A report item only appears as the consequence of an accepted command item.
    a_report_from_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(accept))
        else $error("report item appeared without an accepted command item");

    a_position_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != ST_OK |-> out_position_reg == 12'd0)
        else $error("nonzero position on a failed report");

    a_sync_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_IDLE |-> sync_inc <= (SF_W + 1)'(SYNC_LIMIT))
        else $error("sync failure count passed its limit while parsing");

    a_body_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> index_ext < total)
        else $error("body index beyond packet length");

    a_no_emit_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !out_valid_reg || report.ready)
        else $error("report produced while the output register was blocked");

endmodule

`default_nettype wire
